// File: rtl/psp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package psp_pkg;

  localparam int unsigned DefIdBytes     = 20;
  localparam int unsigned DefMaxPaths    = 16;
  localparam int unsigned DefMaxElements = 16;

  // field byte index and the saturated path and element indices on the result
  localparam int unsigned FidxW = 5;
  localparam int unsigned IdxW  = 4;

  localparam logic [7:0] TypeEndSet  = 8'h00;
  localparam logic [7:0] TypeEndPath = 8'hFF;
  localparam logic [7:0] TypeMask    = 8'h31;

  // parse phase, doubles as the byte role of field bytes
  typedef enum logic [1:0] {
    PH_TYPE     = 2'd0,
    PH_ACCOUNT  = 2'd1,
    PH_CURRENCY = 2'd2,
    PH_ISSUER   = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_EMPTY_PATH = 2'd1,
    ST_BAD_TYPE   = 2'd2
  } status_e;

  localparam logic [2:0] FlAccount  = 3'b001;
  localparam logic [2:0] FlCurrency = 3'b010;
  localparam logic [2:0] FlIssuer   = 3'b100;

  typedef struct packed {
    phase_e             byte_role;
    logic [FidxW-1:0]   field_byte_index;
    logic [IdxW-1:0]    path_index;
    logic [IdxW-1:0]    element_index;
    logic [2:0]         element_flags;
    logic               element_done;
    logic               path_done;
    logic               set_done;
    status_e            status;
  } result_t;

  // first field present strictly after the given phase, PH_TYPE if none
  function automatic phase_e next_field(phase_e cur, logic [2:0] flags);
    phase_e nxt;
    nxt = PH_TYPE;
    if (cur == PH_TYPE && (flags & FlAccount) != 3'b000) begin
      nxt = PH_ACCOUNT;
    end else if ((cur == PH_TYPE || cur == PH_ACCOUNT) && (flags & FlCurrency) != 3'b000) begin
      nxt = PH_CURRENCY;
    end else if (cur != PH_ISSUER && (flags & FlIssuer) != 3'b000) begin
      nxt = PH_ISSUER;
    end
    return nxt;
  endfunction

endpackage

`default_nettype wire

// File: rtl/psp_stream_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface psp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface psp_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] byte_role;
  logic [4:0] field_byte_index;
  logic [3:0] path_index;
  logic [3:0] element_index;
  logic [2:0] element_flags;
  logic       element_done;
  logic       path_done;
  logic       set_done;
  logic [1:0] status;

  modport source (
    output valid, output byte_role, output field_byte_index, output path_index,
    output element_index, output element_flags, output element_done,
    output path_done, output set_done, output status, input ready
  );
  modport sink (
    input valid, input byte_role, input field_byte_index, input path_index,
    input element_index, input element_flags, input element_done,
    input path_done, input set_done, input status, output ready
  );
endinterface

`default_nettype wire

// File: rtl/psp_in_reg.sv
`timescale 1ns / 1ps
`default_nettype none

module psp_in_reg (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  psp_byte_if.sink    in_i,
  input  wire logic   adv_i,
  output logic        valid_o,
  output logic [7:0]  byte_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic       take;

  assign in_i.ready = !valid_q || adv_i;
  assign take       = in_i.valid && in_i.ready;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (adv_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      byte_q <= in_i.data_byte;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule

`default_nettype wire

// File: rtl/psp_parse.sv
`timescale 1ns / 1ps
`default_nettype none

module psp_parse import psp_pkg::*; #(
  parameter int unsigned ID_BYTES     = DefIdBytes,
  parameter int unsigned MAX_PATHS    = DefMaxPaths,
  parameter int unsigned MAX_ELEMENTS = DefMaxElements
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       step_i,
  input  wire logic [7:0] byte_i,
  output result_t         res_o
);

  localparam int unsigned PathW = $clog2(MAX_PATHS);
  localparam int unsigned ElemW = $clog2(MAX_ELEMENTS);

  phase_e             phase_q, phase_d;
  logic [FidxW-1:0]   bcnt_q, bcnt_d;
  logic [2:0]         flags_q, flags_d;
  logic [ElemW-1:0]   elem_q, elem_d;
  logic [PathW-1:0]   path_q, path_d;
  logic               nonempty_q, nonempty_d;
  logic [7:0]         path_wide, elem_wide;
  logic               clear;

  assign path_wide = 8'(path_q);
  assign elem_wide = 8'(elem_q);

  always_comb begin
    phase_d    = phase_q;
    bcnt_d     = bcnt_q;
    flags_d    = flags_q;
    elem_d     = elem_q;
    path_d     = path_q;
    nonempty_d = nonempty_q;
    clear      = 1'b0;

    res_o                  = '0;
    res_o.byte_role        = PH_TYPE;
    res_o.status           = ST_OK;
    res_o.path_index       = path_wide[IdxW-1:0];
    res_o.element_index    = elem_wide[IdxW-1:0];

    if (phase_q == PH_TYPE) begin
      if (byte_i == TypeEndSet || byte_i == TypeEndPath) begin
        if (!nonempty_q) begin
          res_o.status   = ST_EMPTY_PATH;
          res_o.set_done = 1'b1;
          clear          = 1'b1;
        end else begin
          res_o.path_done = 1'b1;
          if (byte_i == TypeEndSet) begin
            res_o.set_done = 1'b1;
            clear          = 1'b1;
          end else begin
            if (path_q != PathW'(MAX_PATHS - 1)) begin
              path_d = path_q + PathW'(1);
            end
            elem_d     = '0;
            nonempty_d = 1'b0;
            flags_d    = '0;
          end
        end
      end else if ((byte_i & ~TypeMask) != 8'h00) begin
        res_o.status   = ST_BAD_TYPE;
        res_o.set_done = 1'b1;
        clear          = 1'b1;
      end else begin
        flags_d             = {byte_i[5], byte_i[4], byte_i[0]};
        res_o.element_flags = flags_d;
        nonempty_d          = 1'b1;
        bcnt_d              = '0;
        phase_d             = next_field(PH_TYPE, flags_d);
      end
    end else begin
      res_o.byte_role        = phase_q;
      res_o.field_byte_index = bcnt_q;
      res_o.element_flags    = flags_q;
      if (bcnt_q == FidxW'(ID_BYTES - 1)) begin
        bcnt_d  = '0;
        phase_d = next_field(phase_q, flags_q);
        if (phase_d == PH_TYPE) begin
          res_o.element_done = 1'b1;
          if (elem_q != ElemW'(MAX_ELEMENTS - 1)) begin
            elem_d = elem_q + ElemW'(1);
          end
        end
      end else begin
        bcnt_d = bcnt_q + FidxW'(1);
      end
    end

    // error or end of set: parsing restarts from reset state
    if (clear) begin
      phase_d    = PH_TYPE;
      bcnt_d     = '0;
      flags_d    = '0;
      elem_d     = '0;
      path_d     = '0;
      nonempty_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_TYPE;
      bcnt_q     <= '0;
      flags_q    <= '0;
      elem_q     <= '0;
      path_q     <= '0;
      nonempty_q <= 1'b0;
    end else if (step_i) begin
      phase_q    <= phase_d;
      bcnt_q     <= bcnt_d;
      flags_q    <= flags_d;
      elem_q     <= elem_d;
      path_q     <= path_d;
      nonempty_q <= nonempty_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/psp_out_reg.sv
`timescale 1ns / 1ps
`default_nettype none

module psp_out_reg import psp_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   valid_i,
  input  wire result_t res_i,
  output logic        free_o,
  psp_result_if.source out_o
);

  logic    valid_q, valid_d;
  result_t res_q;
  logic    load;

  assign free_o = !valid_q || out_o.ready;
  assign load   = valid_i && free_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (out_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res_i;
    end
  end

  assign out_o.valid            = valid_q;
  assign out_o.byte_role        = res_q.byte_role;
  assign out_o.field_byte_index = res_q.field_byte_index;
  assign out_o.path_index       = res_q.path_index;
  assign out_o.element_index    = res_q.element_index;
  assign out_o.element_flags    = res_q.element_flags;
  assign out_o.element_done     = res_q.element_done;
  assign out_o.path_done        = res_q.path_done;
  assign out_o.set_done         = res_q.set_done;
  assign out_o.status           = res_q.status;

endmodule

`default_nettype wire

// File: rtl/path_set_stream_parser_top.sv
// an accepted byte is held in the input register, parsed combinationally and then
// captured in the result register; throughput: one byte per cycle while the result
// register has room, since out_o.ready back-pressure stalls the input register
// reset: rst_ni low clears both valid flags and the parse state (phase, counts,
// flags); the first byte after reset is taken as the first type byte of a set
`timescale 1ns / 1ps
`default_nettype none

module path_set_stream_parser_top import psp_pkg::*; #(
  parameter int unsigned ID_BYTES     = DefIdBytes,
  parameter int unsigned MAX_PATHS    = DefMaxPaths,
  parameter int unsigned MAX_ELEMENTS = DefMaxElements
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  psp_byte_if.sink     in_i,
  psp_result_if.source out_o
);

  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       out_free;
  logic       adv;
  result_t    res;

  assign adv = s1_valid && out_free;

  psp_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .adv_i   (adv),
    .valid_o (s1_valid),
    .byte_o  (s1_byte)
  );

  psp_parse #(
    .ID_BYTES     (ID_BYTES),
    .MAX_PATHS    (MAX_PATHS),
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_parse (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (adv),
    .byte_i (s1_byte),
    .res_o  (res)
  );

  psp_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_valid),
    .res_i   (res),
    .free_o  (out_free),
    .out_o   (out_o)
  );

  // type bytes sit at field position zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.byte_role == PH_TYPE |-> out_o.field_byte_index == '0)
    else $error("type byte with nonzero field index");

  // any error ends the set and closes no path
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.status != ST_OK
      |-> out_o.set_done && !out_o.path_done && out_o.element_flags == 3'b000)
    else $error("error result without set end");

  // an element completes only on the last byte of a field
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.element_done
      |-> out_o.byte_role != PH_TYPE && out_o.field_byte_index == FidxW'(ID_BYTES - 1))
    else $error("element done off the last field byte");

  // a parsed byte is handed on whenever the result register has room
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid && out_free |=> out_o.valid)
    else $error("parsed item lost before result register");

endmodule

`default_nettype wire
